>>> rtl/lmwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwa_pkg
// Shared types and constants of the led matrix wipe animation block.
// ----------------------------------------------------------------------------
package lmwa_pkg;

  // input item kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // tick rate after reset
  localparam logic [15:0] HZ_RESET = 16'd1000;

  // divider iteration counts: tick count by cycle length, position by line step
  localparam int DIV1_STEPS = 32;
  localparam int DIV2_STEPS = 17;
  localparam int ROW_COUNT  = 8;
  localparam int CNT_W      = 6;

  localparam logic [7:0] FULL_LINE = 8'hFF;
  localparam logic [7:0] STATUS_PX = 8'h01;

  typedef enum logic [1:0] {
    PH_DRAW  = 2'd0,
    PH_HOLD  = 2'd1,
    PH_ERASE = 2'd2
  } phase_e;

  // controller to datapath commands
  typedef struct packed {
    logic       start;
    logic       wr_en;
    logic       div_step;
    logic       mod_en;
    logic       pos_setup;
    logic       rd_en;
    logic [2:0] rd_row;
    logic       acc_en;
    logic [2:0] acc_row;
    logic       emit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

>>> rtl/lmwa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwa_ctrl
// Sequencer: tick division, position division, glyph row readout, result load.
// ----------------------------------------------------------------------------
module lmwa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              cmd_i,
  output logic              in_stall_o,
  input  lmwa_pkg::dp_sts_t sts_i,
  output lmwa_pkg::ctrl_cmd_t cmd_o
);
  import lmwa_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV1 = 6'b000010,
    ST_PREP = 6'b000100,
    ST_DIV2 = 6'b001000,
    ST_ROWS = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  localparam logic [CNT_W-1:0] DIV1_LAST = CNT_W'(DIV1_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV2_LAST = CNT_W'(DIV2_STEPS - 1);
  localparam logic [CNT_W-1:0] ROWS_LAST = CNT_W'(ROW_COUNT);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_m1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign cnt_m1     = cnt_q - CNT_W'(1);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (cmd_i == CMD_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        cmd_o.mod_en   = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == DIV1_LAST) begin
          cnt_d   = '0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.pos_setup = 1'b1;
        state_d         = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == DIV2_LAST) begin
          cnt_d   = '0;
          state_d = ST_ROWS;
        end
      end
      ST_ROWS: begin
        // read row n while row n-1 is folded into the frame
        cmd_o.rd_en   = (cnt_q != ROWS_LAST);
        cmd_o.rd_row  = cnt_q[2:0];
        cmd_o.acc_en  = (cnt_q != '0);
        cmd_o.acc_row = cnt_m1[2:0];
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == ROWS_LAST) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/lmwa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwa_datapath
// Tick counter, shared restoring divider, glyph memory, frame builder, output.
// ----------------------------------------------------------------------------
module lmwa_datapath #(
  parameter int SYMBOL_COUNT = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lmwa_pkg::ctrl_cmd_t cmd_i,
  output lmwa_pkg::dp_sts_t   sts_o,
  input  logic                cfg_valid_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [3:0]          glyph_slot_i,
  input  logic [2:0]          glyph_row_i,
  input  logic [7:0]          row_bits_i,
  input  logic                ack_received_i,
  input  logic                bus_off_i,
  input  logic                recovery_active_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         green_frame_o,
  output logic [63:0]         red_frame_o,
  output logic [1:0]          phase_o,
  output logic [3:0]          shown_slot_o
);
  import lmwa_pkg::*;

  localparam int SW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int DEPTH = SYMBOL_COUNT * 8;
  localparam int AW    = SW + 3;
  localparam logic [SW:0] SYM_N = (SW + 1)'(SYMBOL_COUNT);

  // configuration register
  logic [15:0] hz_cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz_cfg_q <= HZ_RESET;
    end else if (cfg_valid_i) begin
      hz_cfg_q <= cfg_data_i;
    end
  end

  // tick counter
  logic [31:0] tick_q, tick_inc;
  assign tick_inc = tick_q + 32'd1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.start) begin
      tick_q <= tick_inc;
    end
  end

  // per-tick timing values
  logic [15:0] hz_eff;
  logic [14:0] half_w;
  logic [11:0] step_w;
  assign hz_eff = (hz_cfg_q == '0) ? 16'd1 : hz_cfg_q;
  assign half_w = hz_eff[15:1];
  assign step_w = (half_w[14:3] == '0) ? 12'd1 : half_w[14:3];

  logic [15:0] hz_q;
  logic [14:0] half_q;
  logic [11:0] step_q;
  logic        ack_q, off_q, recov_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hz_q    <= hz_eff;
      half_q  <= half_w;
      step_q  <= step_w;
      ack_q   <= ack_received_i;
      off_q   <= bus_off_i;
      recov_q <= recovery_active_i;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [31:0] num_q;
  logic [16:0] div_q, rem_q, quo_q;
  logic [SW-1:0] smod_q;
  logic [17:0] rem_ext, div_ext, rem_sub;
  logic        q_bit;
  logic [SW:0] smod_ext, smod_nxt;

  assign rem_ext  = {rem_q, num_q[31]};
  assign div_ext  = {1'b0, div_q};
  assign q_bit    = (rem_ext >= div_ext);
  assign rem_sub  = q_bit ? (rem_ext - div_ext) : rem_ext;
  // slot is the running quotient modulo the symbol count
  assign smod_ext = {smod_q, q_bit};
  assign smod_nxt = (smod_ext >= SYM_N) ? (smod_ext - SYM_N) : smod_ext;

  // phase decision from the tick position
  logic [16:0] pos_w, hold_end, tail_pos;
  assign pos_w    = rem_q;
  assign hold_end = {2'b0, half_q} + {1'b0, hz_q};
  assign tail_pos = pos_w - hold_end;

  phase_e phase_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q  <= tick_inc;
      div_q  <= {hz_eff, 1'b0};
      rem_q  <= '0;
      smod_q <= '0;
    end else if (cmd_i.pos_setup) begin
      rem_q <= '0;
      div_q <= {5'b0, step_q};
      if (pos_w < {2'b0, half_q}) begin
        phase_q <= PH_DRAW;
        num_q   <= {pos_w, 15'b0};
      end else if (pos_w < hold_end) begin
        phase_q <= PH_HOLD;
        num_q   <= {pos_w, 15'b0};
      end else begin
        phase_q <= PH_ERASE;
        num_q   <= {tail_pos, 15'b0};
      end
    end else if (cmd_i.div_step) begin
      rem_q <= rem_sub[16:0];
      num_q <= {num_q[30:0], 1'b0};
      quo_q <= {quo_q[15:0], q_bit};
      if (cmd_i.mod_en) begin
        smod_q <= smod_nxt[SW-1:0];
      end
    end
  end

  // glyph memory
  logic [7:0]    glyph_mem [DEPTH];
  logic [7:0]    rd_q;
  logic [SW+3:0] wslot_ext;
  logic [AW-1:0] waddr, raddr;
  logic          wr_ok;

  assign wslot_ext = {{SW{1'b0}}, glyph_slot_i};
  assign wr_ok     = (wslot_ext < (SW + 4)'(SYMBOL_COUNT));
  assign waddr     = {wslot_ext[SW-1:0], glyph_row_i};
  assign raddr     = {smod_q, cmd_i.rd_row};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      glyph_mem[waddr] <= row_bits_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= glyph_mem[raddr];
    end
  end

  // row rules for the three phases
  logic       p_ge8;
  logic [2:0] p_lo, p_clamp, draw_line, erase_line, r;
  logic [7:0] g_row, r_row;

  assign p_ge8      = |quo_q[16:3];
  assign p_lo       = quo_q[2:0];
  assign p_clamp    = p_ge8 ? 3'd7 : p_lo;
  assign draw_line  = ~p_lo;
  assign erase_line = ~p_clamp;
  assign r          = cmd_i.acc_row;

  always_comb begin
    g_row = '0;
    r_row = '0;
    case (phase_q)
      PH_DRAW: begin
        if (p_ge8) begin
          g_row = rd_q;
        end else begin
          if (r >= draw_line) g_row = rd_q;
          if (r == draw_line) g_row = g_row | FULL_LINE;
        end
      end
      PH_HOLD: begin
        g_row = rd_q;
      end
      PH_ERASE: begin
        if (r < erase_line) g_row = rd_q;
        if (r == erase_line) r_row = FULL_LINE;
      end
      default: begin
        g_row = '0;
        r_row = '0;
      end
    endcase
  end

  // frame accumulation
  logic [63:0] green_q, red_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_setup) begin
      green_q <= '0;
      red_q   <= '0;
    end else if (cmd_i.acc_en) begin
      green_q <= green_q | ({56'b0, g_row} << {r, 3'b0});
      red_q   <= red_q | ({56'b0, r_row} << {r, 3'b0});
    end
  end

  // bus status pixel at row 7 bit 0
  logic [63:0] px, green_fin, red_fin;
  logic        show_px;
  assign px      = {STATUS_PX, 56'b0};
  assign show_px = !(ack_q && !off_q);
  always_comb begin
    green_fin = green_q;
    red_fin   = red_q;
    if (show_px) begin
      if (recov_q) begin
        green_fin = green_q | px;
        red_fin   = red_q | px;
      end else if (off_q) begin
        red_fin = red_q | px;
      end else begin
        green_fin = green_q | px;
      end
    end
  end

  // output register
  logic        out_valid_q;
  logic [SW+3:0] slot_ext;
  assign slot_ext = {4'b0, smod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      green_frame_o <= green_fin;
      red_frame_o   <= red_fin;
      phase_o       <= phase_q;
      shown_slot_o  <= slot_ext[3:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  // divider remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  // running slot stays below the symbol count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_en |-> ({1'b0, smod_q} < SYM_N))
    else $error("slot modulo out of range");

  // a loaded result is presented on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("result load without valid");

endmodule

>>> rtl/led_matrix_wipe_animation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_wipe_animation
// Builds one red/green 8x8 wipe frame per tick, with a bus status pixel.
// ----------------------------------------------------------------------------
//  channel  handshake                      payload
//  in       in_valid_i / in_stall_o        cmd, glyph slot/row, row bits, bus status
//  out      out_valid_o / out_stall_i      green frame, red frame, phase, shown slot
//  cfg      cfg_valid_i / cfg_ready_o      ticks per second (16 bit)
//
//  a row write is taken at once while idle; a tick runs the divider for tick
//  count by cycle length, then for position by line step, then reads the glyph
//  memory, one row per cycle on its single read port.
//  reset clears the tick count, the sequencer and output valid; glyph rows
//  hold nothing defined until written.
//  a stalled result sits in the output register; the next tick waits only
//  at its final load while that register is still occupied.
// ----------------------------------------------------------------------------
module led_matrix_wipe_animation #(
  parameter int SYMBOL_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  glyph_slot_i,
  input  logic [2:0]  glyph_row_i,
  input  logic [7:0]  row_bits_i,
  input  logic        ack_received_i,
  input  logic        bus_off_i,
  input  logic        recovery_active_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] green_frame_o,
  output logic [63:0] red_frame_o,
  output logic [1:0]  phase_o,
  output logic [3:0]  shown_slot_o
);
  import lmwa_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  lmwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  lmwa_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .sts_o             (dp_sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .glyph_slot_i      (glyph_slot_i),
    .glyph_row_i       (glyph_row_i),
    .row_bits_i        (row_bits_i),
    .ack_received_i    (ack_received_i),
    .bus_off_i         (bus_off_i),
    .recovery_active_i (recovery_active_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .green_frame_o     (green_frame_o),
    .red_frame_o       (red_frame_o),
    .phase_o           (phase_o),
    .shown_slot_o      (shown_slot_o)
  );

endmodule
